/* rtl/iidl_pkg.sv */
// ----------------------------------------------------------------------------
// iidl_pkg : shared types and constants of the indexed insert/delete list
// Word field widths, action and status codes, controller states and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package iidl_pkg;

	localparam int ACT_W     = 3;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 7;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 48;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ    = 3'd0,
		ACT_INS_HD  = 3'd1,
		ACT_INS_TL  = 3'd2,
		ACT_INS_POS = 3'd3,
		ACT_DEL_HD  = 3'd4,
		ACT_DEL_TL  = 3'd5,
		ACT_DEL_POS = 3'd6,
		ACT_IGNORE  = 3'd7
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_INSERT,
		OP_DELETE
	} op_kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_RD_REQ,
		S_RD_DATA,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic latch_req;
		logic decide;
		logic rd_pos;
		logic cap_read;
		logic rd_up;
		logic wr_up;
		logic ins;
		logic rd_dn;
		logic wr_dn;
		logic del;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_kind_t kind;
		logic     ok;
		logic     up_more;
		logic     dn_more;
	} stat_t;

endpackage

/* rtl/indexed_insert_delete_list.sv */
// ----------------------------------------------------------------------------
// indexed_insert_delete_list : ordered list with indexed insert and delete
// Sequence: a read passes decide, read request, read data and finish; a failed
// or ignored request passes decide and finish; an insert or delete adds a RAM
// read and a RAM write per shifted entry before finish. Throughput: one
// request at a time. A new word is taken only in idle, at the earliest at the
// edge where the previous result word leaves.
// Reset: arst_n clears the entry count, the state and the output valid; the
// entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] action, [9:3] position, [41:10] item_value, [47:42] zero
	input  logic [47:0] s_tdata,
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [33:2] read_value, [40:34] entry_count, [47:41] zero
	output logic [47:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);

	iidl_pkg::cmd_t  cmd;
	iidl_pkg::stat_t stat;
	logic [CW-1:0]   count;

	// Sequencer: accept a word, decide, read or walk the shift, then load the result.
	iidl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (s_tready),
		.out_valid (m_tvalid)
	);

	// Datapath: hold the request, the count, the store and the result word.
	iidl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (s_tdata),
		.stat     (stat),
		.count    (count),
		.out_word (m_tdata)
	);

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted word keeps the block busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("word accepted while busy");

	// Each insert grows the list by exactly one entry.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (count - $past(count)) == CW'(1))
		else $error("insert did not grow count by one");

	// A loaded result is offered in the next cycle.
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("result word not offered");

endmodule

/* rtl/iidl_ram.sv */
// ----------------------------------------------------------------------------
// iidl_ram : generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iidl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/iidl_ctrl.sv */
// ----------------------------------------------------------------------------
// iidl_ctrl : request sequencer
// Steps one request through decide, read or shift, and result phases.
// ----------------------------------------------------------------------------
module iidl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  iidl_pkg::stat_t stat,
	output iidl_pkg::cmd_t  cmd,
	output logic            in_ready,
	output logic            out_valid
);

	iidl_pkg::state_t state_q, state_nxt;
	logic             out_valid_q;

	assign in_ready  = (state_q == iidl_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			iidl_pkg::S_IDLE: begin
				if (in_valid && in_ready) state_nxt = iidl_pkg::S_DECIDE;
			end
			iidl_pkg::S_DECIDE: begin
				if (!stat.ok) begin
					state_nxt = iidl_pkg::S_FINISH;
				end else begin
					unique case (stat.kind)
						iidl_pkg::OP_READ:   state_nxt = iidl_pkg::S_RD_REQ;
						iidl_pkg::OP_INSERT: state_nxt = iidl_pkg::S_UP_RD;
						iidl_pkg::OP_DELETE: state_nxt = iidl_pkg::S_DN_RD;
						default:             state_nxt = iidl_pkg::S_FINISH;
					endcase
				end
			end
			iidl_pkg::S_RD_REQ:  state_nxt = iidl_pkg::S_RD_DATA;
			iidl_pkg::S_RD_DATA: state_nxt = iidl_pkg::S_FINISH;
			iidl_pkg::S_UP_RD: begin
				state_nxt = stat.up_more ? iidl_pkg::S_UP_WR : iidl_pkg::S_FINISH;
			end
			iidl_pkg::S_UP_WR:   state_nxt = iidl_pkg::S_UP_RD;
			iidl_pkg::S_DN_RD: begin
				state_nxt = stat.dn_more ? iidl_pkg::S_DN_WR : iidl_pkg::S_FINISH;
			end
			iidl_pkg::S_DN_WR:   state_nxt = iidl_pkg::S_DN_RD;
			iidl_pkg::S_FINISH:  state_nxt = iidl_pkg::S_IDLE;
			default:             state_nxt = iidl_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			iidl_pkg::S_IDLE:    cmd.latch_req = in_valid && in_ready;
			iidl_pkg::S_DECIDE:  cmd.decide    = 1'b1;
			iidl_pkg::S_RD_REQ:  cmd.rd_pos    = 1'b1;
			iidl_pkg::S_RD_DATA: cmd.cap_read  = 1'b1;
			iidl_pkg::S_UP_RD: begin
				cmd.rd_up = stat.up_more;
				cmd.ins   = !stat.up_more;
			end
			iidl_pkg::S_UP_WR:   cmd.wr_up     = 1'b1;
			iidl_pkg::S_DN_RD: begin
				cmd.rd_dn = stat.dn_more;
				cmd.del   = !stat.dn_more;
			end
			iidl_pkg::S_DN_WR:   cmd.wr_dn     = 1'b1;
			iidl_pkg::S_FINISH:  cmd.load_out  = 1'b1;
			default:             cmd           = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iidl_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/iidl_dp.sv */
// ----------------------------------------------------------------------------
// iidl_dp : list datapath
// Request registers, entry count, shift index, entry store and result word.
// ----------------------------------------------------------------------------
module iidl_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iidl_pkg::cmd_t             cmd,
	input  logic [iidl_pkg::IN_W-1:0]  in_word,
	output iidl_pkg::stat_t            stat,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic [iidl_pkg::OUT_W-1:0] out_word
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > iidl_pkg::POS_W) ? CW : iidl_pkg::POS_W;
	localparam int PAD_W = iidl_pkg::OUT_W - iidl_pkg::STAT_W - iidl_pkg::VAL_W
	                       - iidl_pkg::CNT_OUT_W;

	iidl_pkg::action_t                act_q;
	logic [iidl_pkg::POS_W-1:0]       pos_q;
	logic [iidl_pkg::VAL_W-1:0]       val_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    idx_q;
	logic [CMP_W-1:0]                 at_q;
	iidl_pkg::status_t                status_q;
	logic [iidl_pkg::VAL_W-1:0]       rv_q;
	iidl_pkg::status_t                out_status_q;
	logic [iidl_pkg::VAL_W-1:0]       out_value_q;
	logic [iidl_pkg::CNT_OUT_W-1:0]   out_count_q;

	logic [CMP_W-1:0]                 pos_x, cnt_x, at_c;
	iidl_pkg::status_t                status_c;
	iidl_pkg::op_kind_t               kind_c;
	logic                             full_c, empty_c;
	logic [CW:0]                      idx_inc;
	logic [CW-1:0]                    raddr_c;
	logic [iidl_pkg::VAL_W-1:0]       rdata;

	assign pos_x   = CMP_W'(pos_q);
	assign cnt_x   = CMP_W'(count_q);
	assign full_c  = (count_q >= CW'(CAPACITY));
	assign empty_c = (count_q == '0);

	always_comb begin
		unique case (act_q)
			iidl_pkg::ACT_READ:    kind_c = iidl_pkg::OP_READ;
			iidl_pkg::ACT_INS_HD,
			iidl_pkg::ACT_INS_TL,
			iidl_pkg::ACT_INS_POS: kind_c = iidl_pkg::OP_INSERT;
			iidl_pkg::ACT_DEL_HD,
			iidl_pkg::ACT_DEL_TL,
			iidl_pkg::ACT_DEL_POS: kind_c = iidl_pkg::OP_DELETE;
			default:               kind_c = iidl_pkg::OP_NONE;
		endcase
	end

	// effective list position of the request
	always_comb begin
		unique case (act_q)
			iidl_pkg::ACT_INS_HD,
			iidl_pkg::ACT_DEL_HD: at_c = '0;
			iidl_pkg::ACT_INS_TL: at_c = cnt_x;
			iidl_pkg::ACT_DEL_TL: at_c = cnt_x - CMP_W'(1);
			default:              at_c = pos_x;
		endcase
	end

	always_comb begin
		status_c = iidl_pkg::STAT_OK;
		unique case (kind_c)
			iidl_pkg::OP_READ: begin
				if (empty_c)             status_c = iidl_pkg::STAT_EMPTY;
				else if (at_c >= cnt_x)  status_c = iidl_pkg::STAT_RANGE;
			end
			iidl_pkg::OP_INSERT: begin
				if (full_c)              status_c = iidl_pkg::STAT_FULL;
				else if (at_c > cnt_x)   status_c = iidl_pkg::STAT_RANGE;
			end
			iidl_pkg::OP_DELETE: begin
				if (empty_c)             status_c = iidl_pkg::STAT_EMPTY;
				else if (at_c >= cnt_x)  status_c = iidl_pkg::STAT_RANGE;
			end
			default:                 status_c = iidl_pkg::STAT_OK;
		endcase
	end

	assign idx_inc      = {1'b0, idx_q} + (CW + 1)'(1);
	assign stat.kind    = kind_c;
	assign stat.ok      = (status_c == iidl_pkg::STAT_OK);
	assign stat.up_more = (CMP_W'(idx_q) > at_q);
	assign stat.dn_more = (idx_inc < {1'b0, count_q});
	assign count        = count_q;

	always_comb begin
		priority if (cmd.rd_up) raddr_c = idx_q - CW'(1);
		else if (cmd.rd_dn)     raddr_c = idx_inc[CW-1:0];
		else if (cmd.rd_pos)    raddr_c = at_q[CW-1:0];
		else                    raddr_c = idx_q;
	end

	iidl_ram #(
		.WIDTH (iidl_pkg::VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_up || cmd.wr_dn || cmd.ins),
		.waddr (idx_q[AW-1:0]),
		.wdata (cmd.ins ? val_q : rdata),
		.raddr (raddr_c[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.del) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			act_q <= iidl_pkg::action_t'(in_word[iidl_pkg::ACT_W-1:0]);
			pos_q <= in_word[iidl_pkg::ACT_W +: iidl_pkg::POS_W];
			val_q <= in_word[iidl_pkg::ACT_W + iidl_pkg::POS_W +: iidl_pkg::VAL_W];
		end
		if (cmd.decide) begin
			at_q     <= at_c;
			status_q <= status_c;
			idx_q    <= (kind_c == iidl_pkg::OP_INSERT) ? count_q : at_c[CW-1:0];
		end else if (cmd.wr_up) begin
			idx_q <= idx_q - CW'(1);
		end else if (cmd.wr_dn) begin
			idx_q <= idx_inc[CW-1:0];
		end
		if (cmd.cap_read) begin
			rv_q <= rdata;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_count_q  <= cnt_x[iidl_pkg::CNT_OUT_W-1:0];
			if (kind_c == iidl_pkg::OP_READ) begin
				out_value_q <= (status_q == iidl_pkg::STAT_OK) ? rv_q : '1;
			end else begin
				out_value_q <= '0;
			end
		end
	end

	assign out_word = {{PAD_W{1'b0}}, out_count_q, out_value_q, out_status_q};

endmodule

/* tb/list_checker.sv */
// ----------------------------------------------------------------------------
// list_checker : result predictor and scoreboard for the indexed list
// Watches both stream channels, keeps its own copy of the list, predicts the
// result word of every accepted request and compares returned words in order.
// ----------------------------------------------------------------------------
module list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	// [2:0] action, [9:3] position, [41:10] item_value, [47:42] zero
	input  logic [iidl_pkg::IN_W-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// [1:0] status, [33:2] read_value, [40:34] entry_count, [47:41] zero
	input  logic [iidl_pkg::OUT_W-1:0] m_tdata,
	output int                         mismatches,
	output int                         awaiting,
	output int                         list_len
);
	timeunit 1ns;
	timeprecision 1ps;

	// status sits in the lowest bits, as on the bus
	typedef struct packed {
		logic [iidl_pkg::CNT_OUT_W-1:0] entry_count;
		logic [iidl_pkg::VAL_W-1:0]     read_value;
		iidl_pkg::status_t              status;
	} list_result_t;

	logic [iidl_pkg::VAL_W-1:0] cells [CAPACITY];
	int                         fill = 0;
	list_result_t               result_q [$];

	initial begin
		mismatches = 0;
		awaiting   = 0;
		list_len   = 0;
	end

	task automatic open_slot(input int at, input logic [iidl_pkg::VAL_W-1:0] v,
			output iidl_pkg::status_t st);
		if (fill >= CAPACITY) begin
			st = iidl_pkg::STAT_FULL;
		end else if (at > fill) begin
			st = iidl_pkg::STAT_RANGE;
		end else begin
			for (int i = fill; i > at; i--)
				cells[i] = cells[i-1];
			cells[at] = v;
			fill++;
			st = iidl_pkg::STAT_OK;
		end
	endtask

	task automatic close_slot(input int at, output iidl_pkg::status_t st);
		if (fill == 0) begin
			st = iidl_pkg::STAT_EMPTY;
		end else if (at >= fill) begin
			st = iidl_pkg::STAT_RANGE;
		end else begin
			for (int i = at; i + 1 < fill; i++)
				cells[i] = cells[i+1];
			fill--;
			st = iidl_pkg::STAT_OK;
		end
	endtask

	task automatic predict_request(input iidl_pkg::action_t act,
			input logic [iidl_pkg::POS_W-1:0] pos,
			input logic [iidl_pkg::VAL_W-1:0] v, output list_result_t r);
		iidl_pkg::status_t st;
		st           = iidl_pkg::STAT_OK;
		r.read_value = '0;
		case (act)
			iidl_pkg::ACT_READ: begin
				if (fill == 0) begin
					st           = iidl_pkg::STAT_EMPTY;
					r.read_value = '1;
				end else if (pos >= fill) begin
					st           = iidl_pkg::STAT_RANGE;
					r.read_value = '1;
				end else begin
					r.read_value = cells[pos];
				end
			end
			iidl_pkg::ACT_INS_HD:  open_slot(0, v, st);
			iidl_pkg::ACT_INS_TL:  open_slot(fill, v, st);
			iidl_pkg::ACT_INS_POS: open_slot(int'(pos), v, st);
			iidl_pkg::ACT_DEL_HD:  close_slot(0, st);
			iidl_pkg::ACT_DEL_TL: begin
				if (fill == 0)
					st = iidl_pkg::STAT_EMPTY;
				else
					close_slot(fill - 1, st);
			end
			iidl_pkg::ACT_DEL_POS: close_slot(int'(pos), st);
			default: ;
		endcase
		r.status      = st;
		r.entry_count = fill[iidl_pkg::CNT_OUT_W-1:0];
	endtask

	always @(posedge clk) begin
		list_result_t exp_r;
		list_result_t got_r;
		if (arst_n) begin
			// compare the returned word first: it always belongs to an older request
			if (m_tvalid && m_tready) begin
				got_r = list_result_t'(m_tdata[$bits(list_result_t)-1:0]);
				if (result_q.size() == 0) begin
					$display("%0t: result word with nothing expected, actual %h",
						$time, got_r);
					mismatches++;
				end else begin
					exp_r = result_q.pop_front();
					if (got_r.status !== exp_r.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, exp_r.status, got_r.status);
						mismatches++;
					end
					if (got_r.read_value !== exp_r.read_value) begin
						$display("%0t: read_value mismatch, expected %h actual %h",
							$time, exp_r.read_value, got_r.read_value);
						mismatches++;
					end
					if (got_r.entry_count !== exp_r.entry_count) begin
						$display("%0t: entry_count mismatch, expected %0d actual %0d",
							$time, exp_r.entry_count, got_r.entry_count);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_request(iidl_pkg::action_t'(s_tdata[iidl_pkg::ACT_W-1:0]),
					s_tdata[iidl_pkg::ACT_W +: iidl_pkg::POS_W],
					s_tdata[iidl_pkg::ACT_W+iidl_pkg::POS_W +: iidl_pkg::VAL_W], exp_r);
				result_q.push_back(exp_r);
			end
			awaiting = result_q.size();
			list_len = fill;
		end
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb : stimulus and verdict for the indexed insert/delete list
// Drives directed corner requests, then phases of random requests that grow
// the list to full, churn it and drain it to empty, with random idling on
// both channels and two long output stalls; the checker scores every word.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY   = 64;
	localparam int PHASE_LEN  = 120;   // useful requests per random phase
	localparam int RAND_ITEMS = 1400;  // useful random requests in total
	localparam int TAIL_WAIT  = 150;   // beyond the longest shift of a full list

	// request mix per phase kind, indexed by action code
	localparam int KIND_GROW   = 0;
	localparam int KIND_MIXED  = 1;
	localparam int KIND_SHRINK = 2;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	// [2:0] action, [9:3] position, [41:10] item_value, [47:42] zero
	logic [iidl_pkg::IN_W-1:0]  s_tdata  = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	// [1:0] status, [33:2] read_value, [40:34] entry_count, [47:41] zero
	logic [iidl_pkg::OUT_W-1:0] m_tdata;

	int mismatches;
	int awaiting;
	int list_len;

	// largest gap the sender draws before each word; zero for burst stretches
	int send_gap_max = 4;

	int mix [3][8] = '{
		'{10, 22, 22, 26,  5,  5,  7, 3},
		'{20, 10, 10, 20, 10, 10, 17, 3},
		'{10,  5,  5,  8, 20, 20, 29, 3}
	};

	indexed_insert_delete_list #(
		.CAPACITY (CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	list_checker #(
		.CAPACITY (CAPACITY)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.awaiting   (awaiting),
		.list_len   (list_len)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop: far beyond a run in which every request shifts a full list
	// and every word sits out the longest stalls.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Offer one request word. Change inputs on the falling edge only, and hold
	// the word until the rising edge that takes it.
	task automatic send_word(input iidl_pkg::action_t act,
			input logic [iidl_pkg::POS_W-1:0] pos, input logic [iidl_pkg::VAL_W-1:0] v);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(iidl_pkg::IN_W-iidl_pkg::ACT_W-iidl_pkg::POS_W-iidl_pkg::VAL_W){1'b0}},
			v, pos, act};
		do @(posedge clk); while (!s_tready);
	endtask

	// Favour the limits of the signed range
	function automatic logic [iidl_pkg::VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal positions up to the live count (the count itself is the
	// boundary), some anywhere in the field, some at the capacity.
	function automatic logic [iidl_pkg::POS_W-1:0] rand_position();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return iidl_pkg::POS_W'(CAPACITY);
		if (r < 3)
			return iidl_pkg::POS_W'($urandom_range(0, (1 << iidl_pkg::POS_W) - 1));
		return iidl_pkg::POS_W'($urandom_range(0, list_len));
	endfunction

	function automatic iidl_pkg::action_t pick_action(input int kind);
		int r;
		int acc;
		r   = $urandom_range(0, 99);
		acc = 0;
		for (int k = 0; k < 8; k++) begin
			acc += mix[kind][k];
			if (r < acc)
				return iidl_pkg::action_t'(k);
		end
		return iidl_pkg::ACT_IGNORE;
	endfunction

	// Receiver: draw a stall per word, drop it for some stretches, and twice
	// hold off for a long while so the block backs up into its input.
	initial begin
		int gap;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (taken == 150 || taken == 800)
				gap = 300;
			else if ((taken / 64) % 4 == 3)
				gap = 0;
			else
				gap = $urandom_range(0, 4);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	initial begin
		int useful;
		int phase;
		int kind;
		int plan [6];
		iidl_pkg::action_t act;

		plan = '{KIND_GROW, KIND_GROW, KIND_MIXED, KIND_SHRINK, KIND_SHRINK, KIND_MIXED};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty list: every read and delete must report empty
		send_word(iidl_pkg::ACT_READ,    7'd0, 32'h0);
		send_word(iidl_pkg::ACT_DEL_HD,  7'd0, 32'h0);
		send_word(iidl_pkg::ACT_DEL_TL,  7'd0, 32'h0);
		send_word(iidl_pkg::ACT_DEL_POS, 7'd0, 32'h0);
		// ignored action: no change, zero result
		send_word(iidl_pkg::ACT_IGNORE,  7'h7f, 32'hffff_ffff);
		// insert beyond the count of an empty list
		send_word(iidl_pkg::ACT_INS_POS, 7'd1, 32'h1234_5678);
		// build a short list with the extremes of the value range
		send_word(iidl_pkg::ACT_INS_HD,  7'd0, 32'h7fff_ffff);
		send_word(iidl_pkg::ACT_INS_TL,  7'd0, 32'h8000_0000);
		send_word(iidl_pkg::ACT_INS_POS, 7'd1, 32'hffff_ffff);
		// insert at the count appends at the tail
		send_word(iidl_pkg::ACT_INS_POS, 7'd3, 32'h0000_0000);
		send_word(iidl_pkg::ACT_INS_POS, 7'h7f, 32'h5555_aaaa);
		send_word(iidl_pkg::ACT_READ,    7'd0, 32'h0);
		send_word(iidl_pkg::ACT_READ,    7'd1, 32'h0);
		send_word(iidl_pkg::ACT_READ,    7'd2, 32'h0);
		send_word(iidl_pkg::ACT_READ,    7'd3, 32'h0);
		// reads and deletes at and beyond the count
		send_word(iidl_pkg::ACT_READ,    7'd4, 32'h0);
		send_word(iidl_pkg::ACT_READ,    7'h7f, 32'h0);
		send_word(iidl_pkg::ACT_DEL_POS, 7'd4, 32'h0);
		send_word(iidl_pkg::ACT_DEL_POS, 7'd64, 32'h0);
		// close gaps from the middle and both ends
		send_word(iidl_pkg::ACT_DEL_POS, 7'd1, 32'h0);
		send_word(iidl_pkg::ACT_DEL_HD,  7'd0, 32'h0);
		send_word(iidl_pkg::ACT_DEL_TL,  7'd0, 32'h0);
		send_word(iidl_pkg::ACT_READ,    7'd0, 32'h0);
		send_word(iidl_pkg::ACT_IGNORE,  7'd0, 32'h0);

		// Random phases: grow to full, churn, drain to empty. Ignored
		// requests are noise and do not advance the phase.
		useful = 0;
		phase  = 0;
		while (useful < RAND_ITEMS) begin
			kind         = plan[phase % 6];
			send_gap_max = (phase % 3 == 2) ? 0 : 4;
			for (int n = 0; n < PHASE_LEN && useful < RAND_ITEMS; ) begin
				act = pick_action(kind);
				send_word(act, rand_position(), rand_value());
				if (act != iidl_pkg::ACT_IGNORE) begin
					n++;
					useful++;
				end
			end
			phase++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain, then allow for a last shift still in flight
		wait (awaiting == 0);
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
